@@ src/dmsw_pkg.sv @@
// ----------------------------------------------------------------------------
// dmsw_pkg
// Shared types, constants and the dither decision for the dithered mono
// span writer.
// ----------------------------------------------------------------------------
package dmsw_pkg;

  // Default store geometry
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 64;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEN_LEVEL     = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2,
    CFG_DITHER_TABLE  = 2'd3
  } dmsw_cfg_e;

  // Register reset values
  localparam logic [7:0]  PEN_RESET    = 8'd0;
  localparam logic [7:0]  WIDTH_RESET  = 8'd128;
  localparam logic [6:0]  HEIGHT_RESET = 7'd64;
  localparam logic [63:0] DITHER_RESET = 64'h5D7F_91B3_6E4C_A280;

  // Pen levels with a fixed outcome
  localparam logic [7:0] PEN_BLACK = 8'd0;
  localparam logic [7:0] PEN_WHITE = 8'd15;

  // Highest bit position inside a vertical byte
  localparam logic [2:0] BIT_TOP = 3'b111;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } dmsw_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN,
    ST_DRAIN,
    ST_READ
  } dmsw_state_e;

  // Control decoded by the sequencer for the datapath
  typedef struct packed {
    logic load_span;
    logic load_quick;
    logic load_read;
    logic issue;
    logic finish_span;
    logic finish_read;
  } dmsw_ctrl_t;

  // Dither decision for one pixel
  function automatic logic dmsw_pixel_bit(input logic [7:0]  pen,
                                          input logic [63:0] thr_table,
                                          input logic [1:0]  col_lo,
                                          input logic [1:0]  row_lo);
    logic [3:0] idx;
    logic [3:0] thr;
    idx = {row_lo, col_lo};
    thr = thr_table[{idx, 2'b00} +: 4];
    if (pen == PEN_BLACK) begin
      return 1'b0;
    end else if (pen == PEN_WHITE) begin
      return 1'b1;
    end else begin
      return pen > {4'd0, thr};
    end
  endfunction

endpackage

@@ src/dmsw_frame_ram.sv @@
// ----------------------------------------------------------------------------
// dmsw_frame_ram
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dmsw_frame_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/dithered_mono_span_writer_core.sv @@
// ----------------------------------------------------------------------------
// dithered_mono_span_writer_core
// Ordered-dither span writer into a 1-bit vertical-byte frame store.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Each request
// yields exactly one result on done_o, for one cycle, and the receiver
// cannot hold it off. A draw whose row is at or past the height, whose start
// is at or past the width, or whose length is zero completes without leaving
// the idle state. A draw of n pixels after clipping passes through the span
// and drain states: the frame store has one write port and each pixel is one
// read-modify-write of its byte, issued one per cycle with the read of the
// next pixel overlapping the write of the current one. After reset the store
// is swept to zero, one byte a cycle, MAX_WIDTH*MAX_HEIGHT/8 bytes (1024 at
// the defaults); busy_o stays high during the sweep, while configuration
// writes are still taken. Outside the sweep, register writes are held off
// while a request is in flight or being offered on start_i.
// ----------------------------------------------------------------------------
module dithered_mono_span_writer_core
  import dmsw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 operation_i,
  input  logic [6:0]           x_i,
  input  logic [5:0]           y_i,
  input  logic [7:0]           length_i,
  input  logic [9:0]           byte_address_i,
  // result channel
  output logic                 done_o,
  output logic [7:0]           read_data_o,
  output logic [7:0]           pixels_drawn_o,
  output logic                 dropped_o,
  // configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // --------------------------------------------------------------------------
  // Configuration registers: written only while no request is in flight
  // --------------------------------------------------------------------------
  logic [7:0]  pen_q;
  logic [7:0]  width_q;
  logic [6:0]  height_q;
  logic [63:0] table_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q    <= PEN_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      table_q  <= DITHER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dmsw_cfg_e'(cfg_index_i))
        CFG_PEN_LEVEL:     pen_q    <= cfg_data_i[7:0];
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[7:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[6:0];
        CFG_DITHER_TABLE:  table_q  <= cfg_data_i;
      endcase
    end
  end

  // Effective geometry, capped at the store's limits
  logic [7:0] w_eff;
  logic [6:0] h_eff;

  assign w_eff = (int'(width_q) > MAX_WIDTH) ? 8'(MAX_WIDTH) : width_q;
  assign h_eff = (int'(height_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height_q;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic       accept;
  logic       req_drop;
  logic       req_empty;
  logic [8:0] req_end;
  logic [7:0] req_count;
  logic       req_rd_ok;

  assign accept    = start_i && !busy_o;
  assign req_drop  = {1'b0, y_i} >= h_eff;
  assign req_end   = 9'(x_i) + 9'(length_i);
  // clip at the width
  assign req_count = (req_end > 9'(w_eff)) ? (w_eff - 8'(x_i)) : length_i;
  // start past the width or nothing asked for: no pixel to write
  assign req_empty = ({1'b0, x_i} >= w_eff) || (req_count == 8'd0);
  assign req_rd_ok = int'(byte_address_i) < STORE_BYTES;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  dmsw_state_e state_q, state_d;
  dmsw_ctrl_t  ctrl;
  logic [7:0]  rem_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic        clr_last;

  assign clr_last = clr_cnt_q == ADDR_W'(STORE_BYTES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl    = '0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (dmsw_op_e'(operation_i) == OP_READ) begin
            ctrl.load_read = 1'b1;
            state_d        = ST_READ;
          end else if (req_drop || req_empty) begin
            ctrl.load_quick = 1'b1;
          end else begin
            ctrl.load_span = 1'b1;
            state_d        = ST_SPAN;
          end
        end
      end
      ST_SPAN: begin
        ctrl.issue = 1'b1;
        if (rem_q == 8'd1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last pixel is written back this cycle
        ctrl.finish_span = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_READ: begin
        ctrl.finish_read = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = state_q != ST_IDLE;

  // Take register writes during the sweep, or while idle with no request offered
  assign cfg_ready_o = (state_q == ST_CLEAR) || ((state_q == ST_IDLE) && !start_i);

  // Clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (state_q == ST_CLEAR) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Span walker: one pixel per cycle, column offset x*h kept as a running sum
  // --------------------------------------------------------------------------
  logic [5:0]  y_q;
  logic [1:0]  cx_lo_q;
  logic [14:0] acc_q;
  logic [7:0]  n_q;
  logic        rd_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (ctrl.load_span) begin
      rem_q <= req_count;
    end else if (ctrl.issue) begin
      rem_q <= rem_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_span) begin
      y_q     <= y_i;
      cx_lo_q <= x_i[1:0];
      acc_q   <= 15'(x_i) * 15'(h_eff);
      n_q     <= req_count;
    end else if (ctrl.issue) begin
      // advance one column
      cx_lo_q <= cx_lo_q + 2'd1;
      acc_q   <= acc_q + 15'(h_eff);
    end
    if (ctrl.load_read) begin
      rd_ok_q <= req_rd_ok;
    end
  end

  logic [12:0] pix_sum;
  logic        pix_ok;
  logic        pix_bit;

  assign pix_sum = 13'(y_q[5:3]) + 13'(acc_q[14:3]);
  assign pix_ok  = int'(pix_sum) < STORE_BYTES;
  assign pix_bit = dmsw_pixel_bit(pen_q, table_q, cx_lo_q, y_q[1:0]);

  // --------------------------------------------------------------------------
  // Read-modify-write pipeline
  // --------------------------------------------------------------------------
  logic              s1_valid_q;
  logic              s1_wr_q;
  logic              s1_bit_q;
  logic [ADDR_W-1:0] s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctrl.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.issue) begin
      s1_wr_q   <= pix_ok;
      s1_bit_q  <= pix_bit;
      s1_addr_q <= ADDR_W'(pix_sum);
    end
  end

  logic              lw_valid_q;
  logic [ADDR_W-1:0] lw_addr_q;
  logic [7:0]        lw_data_q;
  logic [7:0]        ram_rdata;
  logic [7:0]        base_byte;
  logic [7:0]        new_byte;
  logic [2:0]        bit_pos;
  logic              span_we;

  // The read of this byte overlapped the previous write: take the written value
  assign base_byte = (lw_valid_q && (lw_addr_q == s1_addr_q)) ? lw_data_q : ram_rdata;
  assign bit_pos   = BIT_TOP - y_q[2:0];
  assign new_byte  = (base_byte & ~(8'd1 << bit_pos)) | (8'(s1_bit_q) << bit_pos);
  assign span_we   = s1_valid_q && s1_wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else begin
      lw_valid_q <= span_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (span_we) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= new_byte;
    end
  end

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = 8'd0;
    end else begin
      ram_we    = span_we;
      ram_waddr = s1_addr_q;
      ram_wdata = new_byte;
    end
  end

  assign ram_raddr = ctrl.issue ? ADDR_W'(pix_sum) : ADDR_W'(byte_address_i);

  dmsw_frame_ram #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic       done_q;
  logic [7:0] read_data_q;
  logic [7:0] pixels_q;
  logic       dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl.load_quick || ctrl.finish_span || ctrl.finish_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_quick) begin
      read_data_q <= 8'd0;
      pixels_q    <= 8'd0;
      dropped_q   <= req_drop;
    end else if (ctrl.finish_span) begin
      read_data_q <= 8'd0;
      pixels_q    <= n_q;
      dropped_q   <= 1'b0;
    end else if (ctrl.finish_read) begin
      // out-of-range byte reads return zero
      read_data_q <= rd_ok_q ? ram_rdata : 8'd0;
      pixels_q    <= 8'd0;
      dropped_q   <= 1'b0;
    end
  end

  assign done_o         = done_q;
  assign read_data_o    = read_data_q;
  assign pixels_drawn_o = pixels_q;
  assign dropped_o      = dropped_q;

endmodule

@@ src/dmsw_checker.sv @@
// ----------------------------------------------------------------------------
// dmsw_checker
// Port-level checks on request and result timing and result contents of the span writer.
// ----------------------------------------------------------------------------
module dmsw_checker
  import dmsw_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       operation_i,
  input logic       done_o,
  input logic [7:0] read_data_o,
  input logic [7:0] pixels_drawn_o,
  input logic       dropped_o
);

  // A result always follows a request or a busy cycle
  a_done_has_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i && !busy_o) || $past(busy_o)))
    else $error("result without a request in flight");

  // A byte read is followed by a busy cycle and then its result
  a_read_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == OP_READ)) |=> busy_o ##1 done_o)
    else $error("read result not delivered on time");

  // A dropped draw reports no pixels and no read data
  a_drop_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && dropped_o) |-> ((pixels_drawn_o == 8'd0) && (read_data_o == 8'd0)))
    else $error("dropped result carries data");

  // A read result reports no pixels
  a_read_no_pixels : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(busy_o) && $past(start_i && !busy_o, 2) &&
     $past(operation_i == OP_READ, 2)) |-> (pixels_drawn_o == 8'd0))
    else $error("read result reports pixels");

endmodule

bind dithered_mono_span_writer_core dmsw_checker u_dmsw_checker (.*);

@@ test/dithered_mono_span_writer_core_checker.sv @@
// ----------------------------------------------------------------------------
// dithered_mono_span_writer_core_checker
// Watches the request, result and register channels of the span writer. It
// keeps its own frame store and register copies, works out the outcome of
// every request taken, and compares each result with the oldest outcome due.
// ----------------------------------------------------------------------------
module dithered_mono_span_writer_core_checker
  import dmsw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 operation_i,
  input  logic [6:0]           x_i,
  input  logic [5:0]           y_i,
  input  logic [7:0]           length_i,
  input  logic [9:0]           byte_address_i,
  input  logic                 done_i,
  input  logic [7:0]           read_data_i,
  input  logic [7:0]           pixels_drawn_i,
  input  logic                 dropped_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o,
  output int                   span_count_o,
  output int                   pixel_count_o,
  output int                   cut_count_o,
  output int                   refused_count_o,
  output int                   read_count_o,
  output int                   reg_write_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES = (MAX_WIDTH * MAX_HEIGHT) / 8;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] pixels_drawn;
    logic       dropped;
  } span_outcome_t;

  logic [7:0]    frame_q [FRAME_BYTES];
  logic [7:0]    pen_q;
  logic [7:0]    width_q;
  logic [6:0]    height_q;
  logic [63:0]   dither_q;
  span_outcome_t outcome_q [$];

  initial begin
    mismatch_count_o  = 0;
    pending_o         = 0;
    span_count_o      = 0;
    pixel_count_o     = 0;
    cut_count_o       = 0;
    refused_count_o   = 0;
    read_count_o      = 0;
    reg_write_count_o = 0;
  end

  function automatic logic shade_bit(input logic [6:0] col, input logic [5:0] row);
    logic [3:0] thr;
    thr = dither_q[4 * int'({row[1:0], col[1:0]}) +: 4];
    if (pen_q == PEN_BLACK) begin
      return 1'b0;
    end
    if (pen_q == PEN_WHITE) begin
      return 1'b1;
    end
    return pen_q > {4'd0, thr};
  endfunction

  // Apply one request to the frame copy and return its outcome
  function automatic span_outcome_t render_request(input logic       op,
                                                   input logic [6:0] x,
                                                   input logic [5:0] y,
                                                   input logic [7:0] len,
                                                   input logic [9:0] addr);
    span_outcome_t res;
    int            w;
    int            h;
    int            n;
    int            col;
    int            byte_idx;
    int            bit_pos;
    res = '0;
    if (op == OP_READ) begin
      if (int'(addr) < FRAME_BYTES) begin
        res.read_data = frame_q[addr];
      end
      return res;
    end
    w = (int'(width_q) > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
    h = (int'(height_q) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q);
    if (int'(y) >= h) begin
      res.dropped = 1'b1;
      return res;
    end
    if (int'(x) >= w) begin
      return res;
    end
    n = int'(len);
    if (int'(x) + n > w) begin
      n = w - int'(x);
    end
    bit_pos = 7 - int'(y[2:0]);
    for (int i = 0; i < n; i++) begin
      col      = int'(x) + i;
      byte_idx = (int'(y) >> 3) + ((col * h) >> 3);
      if (byte_idx < FRAME_BYTES) begin
        frame_q[byte_idx][bit_pos] = shade_bit(col[6:0], y);
      end
    end
    res.pixels_drawn = n[7:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    span_outcome_t got;
    span_outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_q[i] = '0;
      end
      pen_q    = PEN_RESET;
      width_q  = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      dither_q = DITHER_RESET;
      outcome_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        reg_write_count_o++;
        case (cfg_index_i)
          CFG_PEN_LEVEL:     pen_q    = cfg_data_i[7:0];
          CFG_SCREEN_WIDTH:  width_q  = cfg_data_i[7:0];
          CFG_SCREEN_HEIGHT: height_q = cfg_data_i[6:0];
          CFG_DITHER_TABLE:  dither_q = cfg_data_i;
          default: ;
        endcase
      end
      // a result at this edge belongs to an earlier request: check it first
      if (done_i) begin
        got = '{read_data: read_data_i, pixels_drawn: pixels_drawn_i, dropped: dropped_i};
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding: read_data %0d pixels_drawn %0d dropped %0d",
                 got.read_data, got.pixels_drawn, got.dropped);
          mismatch_count_o++;
        end else begin
          want = outcome_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0d, actual %0d", want.read_data, got.read_data);
            mismatch_count_o++;
          end
          if (got.pixels_drawn !== want.pixels_drawn) begin
            $error("pixels_drawn: expected %0d, actual %0d", want.pixels_drawn,
                   got.pixels_drawn);
            mismatch_count_o++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped: expected %0d, actual %0d", want.dropped, got.dropped);
            mismatch_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        want = render_request(operation_i, x_i, y_i, length_i, byte_address_i);
        outcome_q.push_back(want);
        if (operation_i == OP_READ) begin
          read_count_o++;
        end else if (want.dropped) begin
          refused_count_o++;
        end else begin
          span_count_o++;
          pixel_count_o += int'(want.pixels_drawn);
          if (want.pixels_drawn != length_i) begin
            cut_count_o++;
          end
        end
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

@@ test/dithered_mono_span_writer_core_tb.sv @@
// ----------------------------------------------------------------------------
// dithered_mono_span_writer_core_tb
// Drives draw and read requests and register writes into the span writer.
// A directed opening covers the field extremes, clipping, refused rows and
// the fixed pen levels; random phases under varied register settings follow.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module dithered_mono_span_writer_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dmsw_pkg::*;

  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 190;
  // Covers the sweep after reset and the longest span, with plenty of margin
  localparam int STALL_LIMIT = 6000;
  // Cycles to watch for stray results once everything has arrived
  localparam int TAIL_CYCLES = 160;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start_i        = 1'b0;
  logic                 busy_o;
  logic                 operation_i    = 1'b0;
  logic [6:0]           x_i            = '0;
  logic [5:0]           y_i            = '0;
  logic [7:0]           length_i       = '0;
  logic [9:0]           byte_address_i = '0;
  logic                 done_o;
  logic [7:0]           read_data_o;
  logic [7:0]           pixels_drawn_o;
  logic                 dropped_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [63:0]          cfg_data_i     = '0;

  int mismatches;
  int pending;
  int spans;
  int pixels;
  int cut_spans;
  int refused;
  int reads;
  int reg_writes;

  // Register values last written, used to aim the random requests
  int          cur_w       = int'(WIDTH_RESET);
  int          cur_h       = int'(HEIGHT_RESET);
  int unsigned idle_pct    = 13;
  int unsigned stall_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  dithered_mono_span_writer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .x_i            (x_i),
    .y_i            (y_i),
    .length_i       (length_i),
    .byte_address_i (byte_address_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .pixels_drawn_o (pixels_drawn_o),
    .dropped_o      (dropped_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  dithered_mono_span_writer_core_checker span_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .operation_i       (operation_i),
    .x_i               (x_i),
    .y_i               (y_i),
    .length_i          (length_i),
    .byte_address_i    (byte_address_i),
    .done_i            (done_o),
    .read_data_i       (read_data_o),
    .pixels_drawn_i    (pixels_drawn_o),
    .dropped_i         (dropped_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .span_count_o      (spans),
    .pixel_count_o     (pixels),
    .cut_count_o       (cut_spans),
    .refused_count_o   (refused),
    .read_count_o      (reads),
    .reg_write_count_o (reg_writes)
  );

  // Count cycles in which no request, result or register write moves
  always_ff @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("dithered_mono_span_writer_core_tb failed");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Start stays
  // high on return so that a following request can go straight on.
  task automatic issue(input dmsw_op_e   op,
                       input logic [6:0] x,
                       input logic [5:0] y,
                       input logic [7:0] len,
                       input logic [9:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    operation_i    <= op;
    x_i            <= x;
    y_i            <= y;
    length_i       <= len;
    byte_address_i <= addr;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Write one register; valid is left high for the caller to drop
  task automatic write_reg(input dmsw_cfg_e idx, input logic [63:0] value);
    while ($urandom_range(99) < idle_pct) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [7:0]  pen,
                              input logic [7:0]  w,
                              input logic [6:0]  h,
                              input logic [63:0] thr_table);
    write_reg(CFG_PEN_LEVEL, 64'(pen));
    write_reg(CFG_SCREEN_WIDTH, 64'(w));
    write_reg(CFG_SCREEN_HEIGHT, 64'(h));
    write_reg(CFG_DITHER_TABLE, thr_table);
    cfg_valid_i <= 1'b0;
    cur_w = int'(w);
    cur_h = int'(h);
  endtask

  // Drop start and hold until every result due has come back
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly spans inside the visible area and reads of bytes they touch;
  // the rest is unconstrained noise over the full field ranges.
  task automatic random_request();
    int unsigned roll;
    int          w_eff;
    int          h_eff;
    int          col;
    int          row;
    logic [7:0]  len;
    roll  = $urandom_range(99);
    w_eff = (cur_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_w;
    h_eff = (cur_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cur_h;
    col   = (w_eff != 0) ? int'($urandom_range(w_eff - 1)) : int'($urandom_range(127));
    row   = (h_eff != 0) ? int'($urandom_range(h_eff - 1)) : int'($urandom_range(63));
    case ($urandom_range(19))
      0:       len = 8'($urandom_range(255));
      1, 2:    len = 8'($urandom_range(128));
      default: len = 8'($urandom_range(24));
    endcase
    if (roll < 60) begin
      issue(OP_DRAW, 7'(col), 6'(row), len, 10'($urandom_range(1023)));
    end else if (roll < 68) begin
      issue(OP_DRAW, 7'($urandom_range(127)), 6'($urandom_range(63)),
            8'($urandom_range(255)), 10'($urandom_range(1023)));
    end else if (roll < 92) begin
      issue(OP_READ, 7'($urandom_range(127)), 6'($urandom_range(63)),
            8'($urandom_range(255)), 10'((row >> 3) + ((col * h_eff) >> 3)));
    end else begin
      issue(OP_READ, 7'($urandom_range(127)), 6'($urandom_range(63)),
            8'($urandom_range(255)), 10'($urandom_range(1023)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers are taken during the clearing sweep; requests wait for it
    program_regs(8'd9, 8'd128, 7'd64, DITHER_RESET);
    issue(OP_DRAW, 7'd0, 6'd0, 8'd128, 10'd0);       // full row
    issue(OP_DRAW, 7'd127, 6'd63, 8'd255, 10'd1023); // last pixel, cut to one
    issue(OP_DRAW, 7'd100, 6'd37, 8'd200, 10'd512);  // runs past the width
    issue(OP_DRAW, 7'd5, 6'd10, 8'd0, 10'd0);        // empty span
    issue(OP_READ, 7'd0, 6'd0, 8'd0, 10'd0);
    issue(OP_READ, 7'd127, 6'd63, 8'd255, 10'd1023);
    issue(OP_READ, 7'd0, 6'd0, 8'd0, 10'd804);
    settle();

    // Narrow screen, height not a multiple of eight, solid white pen
    program_regs(PEN_WHITE, 8'd100, 7'd20, '1);
    issue(OP_DRAW, 7'd100, 6'd0, 8'd10, 10'd0);      // starts at the width
    issue(OP_DRAW, 7'd99, 6'd19, 8'd50, 10'd0);      // last row and column
    issue(OP_DRAW, 7'd0, 6'd20, 8'd5, 10'd0);        // row at the height
    issue(OP_DRAW, 7'd10, 6'd63, 8'd8, 10'd0);       // row past the height
    issue(OP_READ, 7'd0, 6'd0, 8'd0, 10'd249);
    settle();

    // Zero width and height: every draw is refused
    program_regs(PEN_BLACK, 8'd0, 7'd0, '0);
    issue(OP_DRAW, 7'd0, 6'd0, 8'd128, 10'd0);
    issue(OP_READ, 7'd0, 6'd0, 8'd0, 10'd2);
    settle();

    // Oversized width and height are clamped; a pen above white
    program_regs(8'd200, 8'd255, 7'd127, '0);
    issue(OP_DRAW, 7'd0, 6'd63, 8'd255, 10'd0);
    issue(OP_DRAW, 7'd64, 6'd2, 8'd128, 10'd0);
    issue(OP_READ, 7'd0, 6'd0, 8'd0, 10'd1023);
    issue(OP_READ, 7'd0, 6'd0, 8'd0, 10'd512);
    settle();

    // Pens one either side of the thresholds
    program_regs(8'd1, 8'd128, 7'd64, '0);
    issue(OP_DRAW, 7'd0, 6'd5, 8'd16, 10'd0);
    issue(OP_READ, 7'd0, 6'd0, 8'd0, 10'd0);
    settle();
    program_regs(8'd14, 8'd128, 7'd64, '1);
    issue(OP_DRAW, 7'd0, 6'd5, 8'd16, 10'd0);
    issue(OP_READ, 7'd0, 6'd0, 8'd0, 10'd0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      // the first random phase runs without any idling at all
      idle_pct = (p == 0) ? 0 : 13;
      case (p)
        0: program_regs(8'($urandom_range(1, 14)), 8'd128, 7'd64, DITHER_RESET);
        1: program_regs(8'($urandom_range(1, 14)), 8'($urandom_range(1, 128)),
                        7'(8 * $urandom_range(1, 8)), {$urandom, $urandom});
        2: program_regs(PEN_WHITE, 8'd255, 7'd127, {$urandom, $urandom});
        3: program_regs(8'd255, 8'd1, 7'd8, '0);
        4: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                        7'($urandom_range(127)), '1);
        5: program_regs(PEN_BLACK, 8'd128, 7'd64, {$urandom, $urandom});
        6: program_regs(8'($urandom_range(2, 14)), 8'd128, 7'd64, {$urandom, $urandom});
        default: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                              7'($urandom_range(127)), {$urandom, $urandom});
      endcase
      repeat (PHASE_ITEMS) random_request();
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d spans (%0d pixels, %0d cut short), %0d refused rows, %0d reads,",
             spans, pixels, cut_spans, refused, reads);
    $display("  across %0d register writes in %0d random phases; %0d mismatches",
             reg_writes, PHASES, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("dithered_mono_span_writer_core_tb passed");
    end else begin
      $display("dithered_mono_span_writer_core_tb failed");
    end
    $finish;
  end

endmodule
